[sv/ggd_pkg.sv]
// Shared types, constants and functions for the glyph grid decoder.
// Depends on nothing; used by the decode stage, the top level and the checker.
`default_nettype none

package ggd_pkg;

	localparam int GridW    = 64;
	localparam int PayloadW = 24;
	localparam int CrcW     = 8;
	localparam int WordW    = PayloadW + CrcW;
	localparam int OutW     = 32;

	localparam logic [CrcW-1:0]  CrcPoly  = 8'h07;
	localparam logic [CrcW-1:0]  CrcInit  = 8'h00;
	localparam logic [GridW-1:0] RingMask = 64'hFF81_8181_8181_81FF;

	// Interior corner cells: (1,1), (1,6), (6,1), (6,6).
	localparam int CornerTl = 9;
	localparam int CornerTr = 14;
	localparam int CornerBl = 49;
	localparam int CornerBr = 54;

	typedef struct packed {
		logic [PayloadW-1:0] payload;
		logic                ok;
	} ggd_result_t;

	localparam int ResultW = $bits(ggd_result_t);

	// CRC of a 24-bit message that has only bit i set. The CRC is linear, so the
	// CRC of any message is the XOR of these for its set bits.
	function automatic logic [PayloadW-1:0][CrcW-1:0] crc_basis();
		logic [PayloadW-1:0][CrcW-1:0] tbl;
		logic [PayloadW-1:0]           msg;
		logic [CrcW-1:0]               c;
		logic                          fb;
		for (int i = 0; i < PayloadW; i++) begin
			msg = PayloadW'(1) << i;
			c   = CrcInit;
			for (int b = PayloadW - 1; b >= 0; b--) begin
				fb = c[CrcW-1] ^ msg[b];
				c  = {c[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
			end
			tbl[i] = c;
		end
		return tbl;
	endfunction

	localparam logic [PayloadW-1:0][CrcW-1:0] CrcBasis = crc_basis();

	function automatic logic [CrcW-1:0] crc24(input logic [PayloadW-1:0] d);
		logic [CrcW-1:0] c;
		c = '0;
		for (int i = 0; i < PayloadW; i++) begin
			if (d[i]) begin
				c = c ^ CrcBasis[i];
			end
		end
		return c;
	endfunction

	// Clockwise quarter turn: cell (r,c) moves to (c,7-r).
	function automatic logic [GridW-1:0] quarter_turn(input logic [GridW-1:0] g);
		logic [GridW-1:0] o;
		o = '0;
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 8; c++) begin
				o[c*8 + 7 - r] = g[r*8 + c];
			end
		end
		return o;
	endfunction

	// Interior cells of rows and columns 1..6, row-major, corners skipped,
	// first cell in the top bit.
	function automatic logic [WordW-1:0] data_word(input logic [GridW-1:0] g);
		logic [WordW-1:0] w;
		int               k;
		w = '0;
		k = WordW - 1;
		for (int r = 1; r <= 6; r++) begin
			for (int c = 1; c <= 6; c++) begin
				if (!((r == 1 || r == 6) && (c == 1 || c == 6))) begin
					w[k[4:0]] = g[r*8 + c];
					k = k - 1;
				end
			end
		end
		return w;
	endfunction

	function automatic logic corners_good(input logic [GridW-1:0] g);
		return g[CornerTl] && !g[CornerTr] && !g[CornerBl] && !g[CornerBr];
	endfunction

endpackage

`default_nettype wire

[sv/glyph_grid_decoder.sv]
// Path: a grid goes into the input register, through the decode, and into the result register,
// which drives m_tvalid and m_tdata.
// Throughput: one grid per cycle unless m_tready stalls the result register; the decode is a
// single pass of fixed wiring and XOR trees between the two registers.
// Reset: arst_n clears both valid flags asynchronously; data registers keep no reset.
`default_nettype none

module glyph_grid_decoder (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [ggd_pkg::GridW-1:0]   s_tdata,  // [63:0] grid_bits
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [ggd_pkg::OutW-1:0]         m_tdata   // [0] ok, [24:1] payload, [31:25] zero
);
	import ggd_pkg::*;

	logic             valid_s1;
	logic [GridW-1:0] grid_s1;
	logic             valid_s2;
	ggd_result_t      res_s2;
	ggd_result_t      res_comb;
	logic             adv_s2;
	logic             adv_s1;

	// The result register loads whenever it is empty or its transfer completes.
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	ggd_decode u_decode (
		.grid   (grid_s1),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			grid_s1 <= s_tdata;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(OutW - ResultW)'(0), res_s2};

endmodule

`default_nettype wire

[sv/ggd_decode.sv]
// Combinational decode of one 8x8 grid in all four orientations.
// Depends on ggd_pkg for the rotation, data extraction and CRC functions.
`default_nettype none

module ggd_decode (
	input  wire logic [ggd_pkg::GridW-1:0] grid,
	output ggd_pkg::ggd_result_t           result
);
	import ggd_pkg::*;

	logic [3:0][GridW-1:0]    rot;
	logic [3:0][WordW-1:0]    word;
	logic [3:0]               pass;
	logic                     ring_good;

	// The outer ring is the same in every orientation.
	assign ring_good = (grid & RingMask) == RingMask;

	assign rot[0] = grid;
	assign rot[1] = quarter_turn(grid);
	assign rot[2] = quarter_turn(rot[1]);
	assign rot[3] = quarter_turn(rot[2]);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			word[i] = data_word(rot[i]);
			pass[i] = ring_good && corners_good(rot[i]) &&
				(crc24(word[i][WordW-1:CrcW]) == word[i][CrcW-1:0]);
		end
	end

	// The earliest orientation that passes wins.
	always_comb begin
		result.ok      = 1'b0;
		result.payload = '0;
		for (int i = 3; i >= 0; i--) begin
			if (pass[i]) begin
				result.ok      = 1'b1;
				result.payload = word[i][WordW-1:CrcW];
			end
		end
	end

endmodule

`default_nettype wire

[sv/ggd_checker.sv]
// Port-level checks for glyph_grid_decoder, attached by the bind at the end.
// Depends on ggd_pkg for widths.
`default_nettype none

module ggd_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tready,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [ggd_pkg::OutW-1:0]  m_tdata
);
	import ggd_pkg::*;

	// A stalled result keeps its valid.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result valid dropped while stalled");

	// A stalled result keeps its data.
	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// A failed decode carries a zero payload.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[PayloadW:1] == '0)
		else $error("nonzero payload on failed decode");

	// The padding above the result stays zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OutW-1:ResultW] == '0)
		else $error("padding bits set");

	// With the result side empty, the input side is never held off.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind glyph_grid_decoder ggd_checker u_ggd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
